[sv/cpu8_pkg.sv]
// Shared types and constants for the code page to UTF-8 transcoder.
package cpu8_pkg;

    localparam int TABLE_DEPTH = 128;
    localparam int TABLE_AW    = 7;
    localparam int CODE_W      = 16;

    localparam logic [TABLE_AW-1:0] TABLE_TOP = 7'd127;

    localparam logic [1:0] REQ_LOAD   = 2'd0;
    localparam logic [1:0] REQ_ENCODE = 2'd1;
    localparam logic [1:0] REQ_DECODE = 2'd2;

    localparam logic [CODE_W-1:0] ASCII_LIMIT    = 16'h0080;
    localparam logic [CODE_W-1:0] TWO_BYTE_LIMIT = 16'h0800;
    localparam logic [7:0]        FILL_BYTE      = 8'h20;
    localparam logic [2:0]        LEAD2_MARK     = 3'b110;
    localparam logic [3:0]        LEAD3_MARK     = 4'b1110;
    localparam logic [1:0]        CONT_MARK      = 2'b10;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [7:0]        data_byte;
        logic              string_last;
        logic [6:0]        table_index;
        logic [CODE_W-1:0] table_value;
    } req_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
    } rsp_t;

endpackage

[sv/codepage_utf8_transcoder.sv]
// Top level of the code page to UTF-8 transcoder with its table lookup sequencer.
//
//   channel   direction   payload          handshake
//   req       in          cpu8_pkg::req_t  req_valid / req_stall
//   rsp       out         cpu8_pkg::rsp_t  rsp_valid / rsp_stall
//
// A load beat writes its table entry without leaving the idle state. An encode beat emits
// its result bytes one at a time, after a table read when the byte is 0x80 or above.
// A decode beat that completes a byte pair scans the table from the top entry down,
// one entry per cycle, before its results are emitted.
// Reset clears the sequencer, the held lead byte and the output valid flag; the table
// is not cleared. No new request beat is taken until the last result byte is in the output register.
module codepage_utf8_transcoder (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  cpu8_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output cpu8_pkg::rsp_t rsp
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_ENC  = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       held_reg, held_next;
    logic [7:0] lead_reg, lead_next;
    logic       rsp_valid_reg, rsp_valid_next;
    logic [1:0] cnt_reg, cnt_next;

    cpu8_pkg::rsp_t rsp_reg, rsp_next;
    logic [2:0][7:0] obuf_reg, obuf_next;
    logic [cpu8_pkg::TABLE_AW-1:0] scan_reg, scan_next;
    logic [11:0] joined_reg, joined_next;
    logic [7:0]  byte_reg, byte_next;
    logic        last_reg, last_next;

    logic                          ram_we;
    logic [cpu8_pkg::TABLE_AW-1:0] ram_raddr;
    logic [cpu8_pkg::CODE_W-1:0]   ram_rdata;

    cpu8_ram #(
        .Width (cpu8_pkg::CODE_W),
        .Depth (cpu8_pkg::TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (req.table_index),
        .wdata (req.table_value),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        if (state_reg == S_SCAN)
        begin
            ram_raddr = scan_reg - 7'd1;
        end
        else if (req.req_type == cpu8_pkg::REQ_DECODE)
        begin
            ram_raddr = cpu8_pkg::TABLE_TOP;
        end
        else
        begin
            ram_raddr = req.data_byte[6:0];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        held_next      = held_reg;
        lead_next      = lead_reg;
        cnt_next       = cnt_reg;
        rsp_next       = rsp_reg;
        obuf_next      = obuf_reg;
        scan_next      = scan_reg;
        joined_next    = joined_reg;
        byte_next      = byte_reg;
        last_next      = last_reg;
        ram_we         = 1'b0;
        rsp_valid_next = rsp_valid_reg && rsp_stall;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    unique case (req.req_type)
                        cpu8_pkg::REQ_LOAD:
                        begin
                            ram_we = 1'b1;
                        end
                        cpu8_pkg::REQ_ENCODE:
                        begin
                            if (req.data_byte[7])
                            begin
                                state_next = S_ENC;
                            end
                            else
                            begin
                                obuf_next[0] = req.data_byte;
                                cnt_next     = 2'd1;
                                state_next   = S_EMIT;
                            end
                        end
                        cpu8_pkg::REQ_DECODE:
                        begin
                            if (held_reg)
                            begin
                                joined_next = {lead_reg[5:0], req.data_byte[5:0]};
                                byte_next   = req.data_byte;
                                last_next   = req.string_last;
                                held_next   = 1'b0;
                                lead_next   = 8'd0;
                                scan_next   = cpu8_pkg::TABLE_TOP;
                                state_next  = S_SCAN;
                            end
                            else if (!req.data_byte[7])
                            begin
                                obuf_next[0] = req.data_byte;
                                cnt_next     = 2'd1;
                                state_next   = S_EMIT;
                            end
                            else if (req.string_last)
                            begin
                                obuf_next[0] = cpu8_pkg::FILL_BYTE;
                                cnt_next     = 2'd1;
                                state_next   = S_EMIT;
                            end
                            else
                            begin
                                held_next = 1'b1;
                                lead_next = req.data_byte;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_ENC:
            begin
                if (ram_rdata < cpu8_pkg::ASCII_LIMIT)
                begin
                    obuf_next[0] = ram_rdata[7:0];
                    cnt_next     = 2'd1;
                end
                else if (ram_rdata < cpu8_pkg::TWO_BYTE_LIMIT)
                begin
                    obuf_next[0] = {cpu8_pkg::LEAD2_MARK, ram_rdata[10:6]};
                    obuf_next[1] = {cpu8_pkg::CONT_MARK, ram_rdata[5:0]};
                    cnt_next     = 2'd2;
                end
                else
                begin
                    obuf_next[0] = {cpu8_pkg::LEAD3_MARK, ram_rdata[15:12]};
                    obuf_next[1] = {cpu8_pkg::CONT_MARK, ram_rdata[11:6]};
                    obuf_next[2] = {cpu8_pkg::CONT_MARK, ram_rdata[5:0]};
                    cnt_next     = 2'd3;
                end
                state_next = S_EMIT;
            end
            S_SCAN:
            begin
                if (ram_rdata == {4'd0, joined_reg})
                begin
                    obuf_next[0] = {1'b1, scan_reg};
                    cnt_next     = 2'd1;
                    state_next   = S_EMIT;
                end
                else if (scan_reg == '0)
                begin
                    // No entry matched: the lead becomes a space and the new byte starts over.
                    obuf_next[0] = cpu8_pkg::FILL_BYTE;
                    state_next   = S_EMIT;
                    if (!byte_reg[7])
                    begin
                        obuf_next[1] = byte_reg;
                        cnt_next     = 2'd2;
                    end
                    else if (last_reg)
                    begin
                        obuf_next[1] = cpu8_pkg::FILL_BYTE;
                        cnt_next     = 2'd2;
                    end
                    else
                    begin
                        cnt_next  = 2'd1;
                        held_next = 1'b1;
                        lead_next = byte_reg;
                    end
                end
                else
                begin
                    scan_next = scan_reg - 7'd1;
                end
            end
            S_EMIT:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next    = 1'b1;
                    rsp_next.out_byte = obuf_reg[0];
                    rsp_next.run_last = (cnt_reg == 2'd1);
                    obuf_next[0]      = obuf_reg[1];
                    obuf_next[1]      = obuf_reg[2];
                    cnt_next          = cnt_reg - 2'd1;
                    if (cnt_reg == 2'd1)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            held_reg      <= 1'b0;
            lead_reg      <= 8'd0;
            rsp_valid_reg <= 1'b0;
            cnt_reg       <= 2'd0;
        end
        else
        begin
            state_reg     <= state_next;
            held_reg      <= held_next;
            lead_reg      <= lead_next;
            rsp_valid_reg <= rsp_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg    <= rsp_next;
        obuf_reg   <= obuf_next;
        scan_reg   <= scan_next;
        joined_reg <= joined_next;
        byte_reg   <= byte_next;
        last_reg   <= last_next;
    end

endmodule

[sv/cpu8_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
module cpu8_ram #(
    parameter int Width = 16,
    parameter int Depth = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);

    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[test/codepage_utf8_transcoder_test.sv]
// Self-checking testbench for the code page to UTF-8 transcoder with directed and random beats.
module codepage_utf8_transcoder_test;

    localparam logic [1:0] REQ_NONE = 2'd3;
    localparam int PREDICTED = -1;
    localparam int RANDOM_BEATS = 270;
    localparam int QUIET_LIMIT = 3000;
    localparam int DRAIN_CYCLES = 300;

    typedef struct {
        cpu8_pkg::req_t beat;
        int             want_n;
        logic [7:0]     want [3];
    } row_t;

    logic clk;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    cpu8_pkg::req_t req = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    cpu8_pkg::rsp_t rsp;

    logic [15:0] code_model [cpu8_pkg::TABLE_DEPTH];
    logic lead_waiting = 1'b0;
    logic [7:0] lead_value = 8'h00;

    cpu8_pkg::rsp_t expected_bytes [$];
    row_t directed_rows [$];
    int fail_count = 0;
    int send_idle = 19;
    int recv_idle = 50;
    int quiet_cycles = 0;

    codepage_utf8_transcoder uut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp(rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int convert_beat(input cpu8_pkg::req_t beat,
                                        output cpu8_pkg::rsp_t [2:0] res);
        int n;
        int i;
        logic [15:0] cp;
        logic [11:0] joined;
        bit found;
        n = 0;
        found = 1'b0;
        res = '0;
        case (beat.req_type)
            cpu8_pkg::REQ_LOAD:
            begin
                code_model[beat.table_index] = beat.table_value;
            end
            cpu8_pkg::REQ_ENCODE:
            begin
                cp = beat.data_byte[7] ? code_model[beat.data_byte[6:0]]
                                       : {8'h00, beat.data_byte};
                if (cp < cpu8_pkg::ASCII_LIMIT)
                begin
                    res[0].out_byte = cp[7:0];
                    n = 1;
                end
                else if (cp < cpu8_pkg::TWO_BYTE_LIMIT)
                begin
                    res[0].out_byte = {cpu8_pkg::LEAD2_MARK, cp[10:6]};
                    res[1].out_byte = {cpu8_pkg::CONT_MARK, cp[5:0]};
                    n = 2;
                end
                else
                begin
                    res[0].out_byte = {cpu8_pkg::LEAD3_MARK, cp[15:12]};
                    res[1].out_byte = {cpu8_pkg::CONT_MARK, cp[11:6]};
                    res[2].out_byte = {cpu8_pkg::CONT_MARK, cp[5:0]};
                    n = 3;
                end
            end
            cpu8_pkg::REQ_DECODE:
            begin
                if (lead_waiting)
                begin
                    joined = {lead_value[5:0], beat.data_byte[5:0]};
                    lead_waiting = 1'b0;
                    lead_value = 8'h00;
                    for (i = cpu8_pkg::TABLE_DEPTH - 1; i >= 0 && !found; i--)
                    begin
                        if (code_model[7'(i)] == {4'h0, joined})
                        begin
                            found = 1'b1;
                            res[0].out_byte = cpu8_pkg::ASCII_LIMIT[7:0] + 8'(i);
                        end
                    end
                    if (!found)
                        res[0].out_byte = cpu8_pkg::FILL_BYTE;
                    n = 1;
                end
                if (!found)
                begin
                    if (!beat.data_byte[7])
                    begin
                        res[2'(n)].out_byte = beat.data_byte;
                        n++;
                    end
                    else if (beat.string_last)
                    begin
                        res[2'(n)].out_byte = cpu8_pkg::FILL_BYTE;
                        n++;
                    end
                    else
                    begin
                        lead_waiting = 1'b1;
                        lead_value = beat.data_byte;
                    end
                end
            end
            default:
            begin
            end
        endcase
        if (n > 0)
            res[2'(n - 1)].run_last = 1'b1;
        return n;
    endfunction

    function automatic row_t make_row(input logic [1:0] kind, input logic [7:0] b,
                                      input logic last, input logic [6:0] idx,
                                      input logic [15:0] val, input int n,
                                      input logic [7:0] w0, input logic [7:0] w1,
                                      input logic [7:0] w2);
        row_t row;
        row.beat.req_type = kind;
        row.beat.data_byte = b;
        row.beat.string_last = last;
        row.beat.table_index = idx;
        row.beat.table_value = val;
        row.want_n = n;
        row.want[0] = w0;
        row.want[1] = w1;
        row.want[2] = w2;
        return row;
    endfunction

    task automatic send_beat(input row_t row);
        cpu8_pkg::rsp_t [2:0] res;
        int n;
        int k;
        while ($urandom_range(0, 99) < send_idle)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= row.beat;
        @(posedge clk);
        while (req_stall !== 1'b0)
            @(posedge clk);
        n = convert_beat(row.beat, res);
        if (row.want_n != PREDICTED)
        begin
            n = row.want_n;
            for (k = 0; k < n; k++)
            begin
                res[2'(k)].out_byte = row.want[2'(k)];
                res[2'(k)].run_last = (k == n - 1);
            end
        end
        for (k = 0; k < n; k++)
            expected_bytes.push_back(res[2'(k)]);
    endtask

    always @(posedge clk)
    begin : check_output
        cpu8_pkg::rsp_t want;
        if (rsp_valid === 1'b1 && rsp_stall === 1'b0)
        begin
            if (expected_bytes.size() == 0)
            begin
                $error("unexpected beat: out_byte %h run_last %b", rsp.out_byte, rsp.run_last);
                fail_count++;
            end
            else
            begin
                want = expected_bytes.pop_front();
                if (rsp.out_byte !== want.out_byte)
                begin
                    $error("out_byte: expected %h, got %h", want.out_byte, rsp.out_byte);
                    fail_count++;
                end
                if (rsp.run_last !== want.run_last)
                begin
                    $error("run_last: expected %b, got %b", want.run_last, rsp.run_last);
                    fail_count++;
                end
            end
        end
        rsp_stall <= ($urandom_range(0, 99) < recv_idle);
    end

    always @(posedge clk)
    begin
        if ((req_valid === 1'b1 && req_stall === 1'b0) ||
            (rsp_valid === 1'b1 && rsp_stall === 1'b0))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        row_t row;
        logic [63:0] pick;
        logic [15:0] v;
        int i;
        int sel;
        int beats;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Every entry is written before the first encode or decode beat.
        for (i = 0; i < cpu8_pkg::TABLE_DEPTH; i++)
        begin
            case ($urandom_range(0, 4))
                0, 1: v = (i > 0) ? code_model[7'($urandom_range(0, i - 1))] : 16'h0041;
                2: v = 16'($urandom_range(0, 12'hFFF));
                3: v = 16'($urandom_range(0, 127));
                default: v = 16'($urandom_range(0, 16'hFFFF));
            endcase
            send_beat(make_row(cpu8_pkg::REQ_LOAD, 8'($urandom), 1'b0, 7'(i), v,
                               0, 8'h00, 8'h00, 8'h00));
        end

        directed_rows.push_back(make_row(cpu8_pkg::REQ_LOAD, 8'h00, 1'b0, 7'd0, 16'h0000,
                                         0, 8'h00, 8'h00, 8'h00));
        directed_rows.push_back(make_row(cpu8_pkg::REQ_LOAD, 8'h00, 1'b0, 7'd1, 16'h007F,
                                         0, 8'h00, 8'h00, 8'h00));
        directed_rows.push_back(make_row(cpu8_pkg::REQ_LOAD, 8'h00, 1'b0, 7'd2, 16'h0080,
                                         0, 8'h00, 8'h00, 8'h00));
        directed_rows.push_back(make_row(cpu8_pkg::REQ_LOAD, 8'h00, 1'b0, 7'd3, 16'h07FF,
                                         0, 8'h00, 8'h00, 8'h00));
        directed_rows.push_back(make_row(cpu8_pkg::REQ_LOAD, 8'h00, 1'b0, 7'd4, 16'h0800,
                                         0, 8'h00, 8'h00, 8'h00));
        directed_rows.push_back(make_row(cpu8_pkg::REQ_LOAD, 8'h00, 1'b0, cpu8_pkg::TABLE_TOP,
                                         16'hFFFF, 0, 8'h00, 8'h00, 8'h00));
        directed_rows.push_back(make_row(cpu8_pkg::REQ_LOAD, 8'h00, 1'b0, 7'd126, 16'h0ABC,
                                         0, 8'h00, 8'h00, 8'h00));
        directed_rows.push_back(make_row(cpu8_pkg::REQ_ENCODE, 8'h00, 1'b0, 7'd0, 16'h0,
                                         1, 8'h00, 8'h00, 8'h00));
        directed_rows.push_back(make_row(cpu8_pkg::REQ_ENCODE, 8'h7F, 1'b0, 7'd0, 16'h0,
                                         1, 8'h7F, 8'h00, 8'h00));
        directed_rows.push_back(make_row(cpu8_pkg::REQ_ENCODE, 8'h80, 1'b0, 7'd0, 16'h0,
                                         1, 8'h00, 8'h00, 8'h00));
        directed_rows.push_back(make_row(cpu8_pkg::REQ_ENCODE, 8'h81, 1'b0, 7'd0, 16'h0,
                                         1, 8'h7F, 8'h00, 8'h00));
        directed_rows.push_back(make_row(cpu8_pkg::REQ_ENCODE, 8'h82, 1'b0, 7'd0, 16'h0,
                                         2, 8'hC2, 8'h80, 8'h00));
        directed_rows.push_back(make_row(cpu8_pkg::REQ_ENCODE, 8'h83, 1'b0, 7'd0, 16'h0,
                                         2, 8'hDF, 8'hBF, 8'h00));
        directed_rows.push_back(make_row(cpu8_pkg::REQ_ENCODE, 8'h84, 1'b0, 7'd0, 16'h0,
                                         3, 8'hE0, 8'hA0, 8'h80));
        directed_rows.push_back(make_row(cpu8_pkg::REQ_ENCODE, 8'hFF, 1'b0, 7'd0, 16'h0,
                                         3, 8'hEF, 8'hBF, 8'hBF));
        directed_rows.push_back(make_row(REQ_NONE, 8'hFF, 1'b1, 7'h7F, 16'hFFFF,
                                         0, 8'h00, 8'h00, 8'h00));
        directed_rows.push_back(make_row(cpu8_pkg::REQ_DECODE, 8'h41, 1'b0, 7'd0, 16'h0,
                                         1, 8'h41, 8'h00, 8'h00));
        directed_rows.push_back(make_row(cpu8_pkg::REQ_DECODE, 8'hC2, 1'b1, 7'd0, 16'h0,
                                         1, cpu8_pkg::FILL_BYTE, 8'h00, 8'h00));
        directed_rows.push_back(make_row(cpu8_pkg::REQ_DECODE, 8'hEA, 1'b0, 7'd0, 16'h0,
                                         0, 8'h00, 8'h00, 8'h00));
        directed_rows.push_back(make_row(cpu8_pkg::REQ_ENCODE, 8'h7F, 1'b0, 7'd0, 16'h0,
                                         1, 8'h7F, 8'h00, 8'h00));
        directed_rows.push_back(make_row(cpu8_pkg::REQ_LOAD, 8'h00, 1'b0, 7'd5, 16'h1234,
                                         0, 8'h00, 8'h00, 8'h00));
        directed_rows.push_back(make_row(REQ_NONE, 8'h00, 1'b0, 7'd0, 16'h0,
                                         0, 8'h00, 8'h00, 8'h00));
        directed_rows.push_back(make_row(cpu8_pkg::REQ_DECODE, 8'hBC, 1'b0, 7'd0, 16'h0,
                                         1, 8'hFE, 8'h00, 8'h00));
        directed_rows.push_back(make_row(cpu8_pkg::REQ_DECODE, 8'hFF, 1'b0, 7'd0, 16'h0,
                                         PREDICTED, 8'h00, 8'h00, 8'h00));
        directed_rows.push_back(make_row(cpu8_pkg::REQ_DECODE, 8'hFF, 1'b1, 7'd0, 16'h0,
                                         PREDICTED, 8'h00, 8'h00, 8'h00));
        directed_rows.push_back(make_row(cpu8_pkg::REQ_DECODE, 8'hC0, 1'b0, 7'd0, 16'h0,
                                         PREDICTED, 8'h00, 8'h00, 8'h00));
        directed_rows.push_back(make_row(cpu8_pkg::REQ_DECODE, 8'h41, 1'b0, 7'd0, 16'h0,
                                         PREDICTED, 8'h00, 8'h00, 8'h00));
        directed_rows.push_back(make_row(cpu8_pkg::REQ_DECODE, 8'h80, 1'b0, 7'd0, 16'h0,
                                         PREDICTED, 8'h00, 8'h00, 8'h00));
        directed_rows.push_back(make_row(cpu8_pkg::REQ_DECODE, 8'h80, 1'b1, 7'd0, 16'h0,
                                         PREDICTED, 8'h00, 8'h00, 8'h00));

        foreach (directed_rows[i])
            send_beat(directed_rows[i]);

        // Most decode beats come as lead and continuation pairs built from table entries.
        beats = 0;
        while (beats < RANDOM_BEATS)
        begin
            if (beats >= 2 * RANDOM_BEATS / 3)
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            else if (beats >= RANDOM_BEATS / 3)
            begin
                send_idle = 50;
                recv_idle = 19;
            end
            pick = {$urandom(), $urandom()};
            row.beat = pick[33:0];
            row.want_n = PREDICTED;
            sel = $urandom_range(0, 99);
            if (sel < 10)
            begin
                row.beat.req_type = cpu8_pkg::REQ_LOAD;
                case ($urandom_range(0, 3))
                    0, 1: row.beat.table_value =
                              code_model[7'($urandom_range(0, cpu8_pkg::TABLE_DEPTH - 1))];
                    2: row.beat.table_value = 16'($urandom_range(0, 12'hFFF));
                    default: row.beat.table_value = pick[15:0];
                endcase
                send_beat(row);
                beats++;
            end
            else if (sel < 35)
            begin
                row.beat.req_type = cpu8_pkg::REQ_ENCODE;
                send_beat(row);
                beats++;
            end
            else if (sel < 75)
            begin
                v = code_model[7'($urandom_range(0, cpu8_pkg::TABLE_DEPTH - 1))];
                if (v >= 16'h1000)
                    v = 16'($urandom_range(0, 12'hFFF));
                row.beat.req_type = cpu8_pkg::REQ_DECODE;
                row.beat.data_byte = {1'b1, pick[40], v[11:6]};
                row.beat.string_last = 1'b0;
                send_beat(row);
                row.beat.data_byte = {($urandom_range(0, 3) == 0) ? pick[42:41]
                                                                   : cpu8_pkg::CONT_MARK,
                                      v[5:0]};
                row.beat.string_last = ($urandom_range(0, 3) == 0);
                send_beat(row);
                beats += 2;
            end
            else if (sel < 92)
            begin
                row.beat.req_type = cpu8_pkg::REQ_DECODE;
                row.beat.string_last = ($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 1) == 0)
                    row.beat.data_byte[7] = 1'b0;
                send_beat(row);
                beats++;
            end
            else
            begin
                row.beat.req_type = REQ_NONE;
                send_beat(row);
            end
        end

        req_valid <= 1'b0;
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[files.f]
sv/cpu8_pkg.sv
sv/cpu8_ram.sv
sv/codepage_utf8_transcoder.sv
test/codepage_utf8_transcoder_test.sv
